[sv/u2u8_pkg.sv]
// ----------------------------------------------------------------------------
// u2u8_pkg
// Shared types and constants for the UTF-16 / Latin-1 to UTF-8 transcoder.
// ----------------------------------------------------------------------------
package u2u8_pkg;

   // configuration register indexes
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE_FORMAT      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEFAULT_BIG_ENDIAN = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_OUTPUT_CAPACITY    = 2'd2;

   localparam int CP_W    = 21;
   localparam int LEN_W   = 3;   // 0..4 bytes of one code point
   localparam int COUNT_W = 3;   // 0..5 beats of one item

   // job queue between front and back
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = 1;
   localparam int Q_CNT_W = 2;

   // byte order marks
   localparam logic [7:0] BOM_FF = 8'hFF;
   localparam logic [7:0] BOM_FE = 8'hFE;

   // surrogate ranges
   localparam logic [15:0] HIGH_FIRST = 16'hD800;
   localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
   localparam logic [15:0] LOW_FIRST  = 16'hDC00;
   localparam logic [15:0] LOW_LAST   = 16'hDFFF;
   localparam logic [CP_W-1:0] CP_PLANE1 = 21'h10000;

   // UTF-8 markers
   localparam logic [7:0] LEAD2     = 8'hC0;
   localparam logic [7:0] LEAD3     = 8'hE0;
   localparam logic [7:0] LEAD4     = 8'hF0;
   localparam logic [7:0] CONT_MARK = 8'h80;
   localparam logic [7:0] CONT_MASK = 8'h3F;

   // one classified item: the code point to send and whether a terminator follows
   typedef struct packed {
      logic [CP_W-1:0]  cp;
      logic [LEN_W-1:0] nbytes;
      logic             term;
   } job_type;

endpackage

[sv/u2u8_ifs.sv]
// ----------------------------------------------------------------------------
// u2u8 channel interfaces
// Valid/ready channels for source bytes, UTF-8 bytes and register writes.
// ----------------------------------------------------------------------------
interface u2u8_req_if;
   logic       valid;
   logic       ready;
   logic       has_byte;
   logic [7:0] source_byte;
   logic       end_of_string;

   modport source (output valid, has_byte, source_byte, end_of_string, input ready);
   modport sink   (input valid, has_byte, source_byte, end_of_string, output ready);
endinterface

interface u2u8_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] utf8_byte;
   logic       is_terminator;
   logic       run_last;

   modport source (output valid, utf8_byte, is_terminator, run_last, input ready);
   modport sink   (input valid, utf8_byte, is_terminator, run_last, output ready);
endinterface

interface u2u8_csr_if #(parameter int DATA_W = 16);
   logic                               valid;
   logic                               ready;
   logic [u2u8_pkg::CSR_INDEX_W-1:0]   index;
   logic [DATA_W-1:0]                  wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

[sv/u2u8_front.sv]
// ----------------------------------------------------------------------------
// u2u8_front
// Pairs bytes into units, handles marks and surrogates, checks the budget.
// ----------------------------------------------------------------------------
module u2u8_front #(
   parameter int CAPACITY_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_fire,
   input  logic                     has_byte,
   input  logic [7:0]               source_byte,
   input  logic                     end_of_string,
   input  logic                     cfg_latin,
   input  logic                     cfg_default_be,
   input  logic [CAPACITY_BITS-1:0] cfg_capacity,
   output logic                     push,
   output u2u8_pkg::job_type        push_job
);

   logic                     stopped_ff, stopped_in;
   logic                     at_start_ff, at_start_in;
   logic                     phase_ff, phase_in;
   logic [7:0]               held_ff, held_in;
   logic                     active_be_ff, active_be_in;
   logic                     pend_valid_ff, pend_valid_in;
   logic [9:0]               pend_bits_ff, pend_bits_in;
   logic [CAPACITY_BITS-1:0] bw_ff, bw_in;

   logic                              cap_zero, mark, be, is_low, is_high, process;
   logic                              stop, enc_req, enc_ok, fits, term;
   logic [15:0]                       unit;
   logic [u2u8_pkg::CP_W-1:0]         enc_cp;
   logic [u2u8_pkg::LEN_W-1:0]        enc_len;
   logic [CAPACITY_BITS:0]            sum;

   always_comb begin
      cap_zero = (cfg_capacity == '0);
      mark = at_start_ff &&
             ((held_ff == u2u8_pkg::BOM_FF && source_byte == u2u8_pkg::BOM_FE) ||
              (held_ff == u2u8_pkg::BOM_FE && source_byte == u2u8_pkg::BOM_FF));
      be      = at_start_ff ? cfg_default_be : active_be_ff;
      unit    = be ? {held_ff, source_byte} : {source_byte, held_ff};
      is_low  = (unit >= u2u8_pkg::LOW_FIRST) && (unit <= u2u8_pkg::LOW_LAST);
      is_high = (unit >= u2u8_pkg::HIGH_FIRST) && (unit <= u2u8_pkg::HIGH_LAST);
      process = in_fire && !cap_zero && !stopped_ff && has_byte;

      stopped_in    = stopped_ff;
      at_start_in   = at_start_ff;
      phase_in      = phase_ff;
      held_in       = held_ff;
      active_be_in  = active_be_ff;
      pend_valid_in = pend_valid_ff;
      pend_bits_in  = pend_bits_ff;
      bw_in         = bw_ff;
      stop          = 1'b0;
      enc_req       = 1'b0;
      enc_cp        = '0;

      if (process) begin
         if (cfg_latin) begin
            at_start_in = 1'b0;
            if (source_byte == 8'd0) begin
               stop = 1'b1;
            end else begin
               enc_req = 1'b1;
               enc_cp  = {13'd0, source_byte};
            end
         end else if (!phase_ff) begin
            held_in  = source_byte;
            phase_in = 1'b1;
         end else begin
            phase_in = 1'b0;
            held_in  = 8'd0;
            if (at_start_ff) begin
               at_start_in  = 1'b0;
               active_be_in = mark ? (held_ff == u2u8_pkg::BOM_FE) : cfg_default_be;
            end
            if (!mark) begin
               pend_valid_in = is_high;
               pend_bits_in  = is_high ? unit[9:0] : 10'd0;
               if (pend_valid_ff && is_low) begin
                  enc_req = 1'b1;
                  enc_cp  = u2u8_pkg::CP_PLANE1 + {1'b0, pend_bits_ff, unit[9:0]};
               end else if (unit == 16'd0) begin
                  stop = 1'b1;
               end else if (!is_high && !is_low) begin
                  enc_req = 1'b1;
                  enc_cp  = {5'd0, unit};
               end
            end
         end
      end

      if (enc_cp < 21'h80) begin
         enc_len = 3'd1;
      end else if (enc_cp < 21'h800) begin
         enc_len = 3'd2;
      end else if (enc_cp < 21'h10000) begin
         enc_len = 3'd3;
      end else begin
         enc_len = 3'd4;
      end

      // one slot always stays free for the terminator
      sum    = {1'b0, bw_ff} + (CAPACITY_BITS+1)'(enc_len);
      fits   = sum < {1'b0, cfg_capacity};
      enc_ok = enc_req && fits;
      if (enc_req && !fits) begin
         stop = 1'b1;
      end
      if (enc_ok) begin
         bw_in = sum[CAPACITY_BITS-1:0];
      end

      term = in_fire && !cap_zero && (stop || (end_of_string && !stopped_ff));

      if (in_fire) begin
         if (stop && !end_of_string) begin
            stopped_in = 1'b1;
         end else if (end_of_string) begin
            stopped_in    = 1'b0;
            at_start_in   = 1'b1;
            phase_in      = 1'b0;
            held_in       = 8'd0;
            active_be_in  = 1'b0;
            pend_valid_in = 1'b0;
            pend_bits_in  = 10'd0;
            bw_in         = '0;
         end
      end

      push            = enc_ok || term;
      push_job.cp     = enc_cp;
      push_job.nbytes = enc_ok ? enc_len : 3'd0;
      push_job.term   = term;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stopped_ff    <= 1'b0;
         at_start_ff   <= 1'b1;
         phase_ff      <= 1'b0;
         held_ff       <= 8'd0;
         active_be_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         pend_bits_ff  <= 10'd0;
         bw_ff         <= '0;
      end else begin
         stopped_ff    <= stopped_in;
         at_start_ff   <= at_start_in;
         phase_ff      <= phase_in;
         held_ff       <= held_in;
         active_be_ff  <= active_be_in;
         pend_valid_ff <= pend_valid_in;
         pend_bits_ff  <= pend_bits_in;
         bw_ff         <= bw_in;
      end
   end

`ifndef SYNTHESIS
   // a stopped string stays silent until its end item
   a_stopped_silent: assert property (@(posedge clock) disable iff (reset)
      (in_fire && stopped_ff && !end_of_string) |-> !push)
      else $error("output after string stopped");

   // a counted code point always leaves the terminator slot free
   a_budget: assert property (@(posedge clock) disable iff (reset)
      enc_ok |-> (bw_in < cfg_capacity))
      else $error("byte budget overrun");
`endif

endmodule

[sv/u2u8_queue.sv]
// ----------------------------------------------------------------------------
// u2u8_queue
// Short job queue between the classifying front and the byte sender.
// ----------------------------------------------------------------------------
module u2u8_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  u2u8_pkg::job_type push_job,
   output logic              full,
   output logic              head_valid,
   output u2u8_pkg::job_type head_job,
   input  logic              pop
);

   u2u8_pkg::job_type                  mem_ff [u2u8_pkg::Q_DEPTH];
   logic [u2u8_pkg::Q_PTR_W-1:0]       wr_ptr_ff, rd_ptr_ff;
   logic [u2u8_pkg::Q_CNT_W-1:0]       count_ff, count_in;

   assign full       = (count_ff == u2u8_pkg::Q_CNT_W'(u2u8_pkg::Q_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("job queue overflow");
`endif

endmodule

[sv/u2u8_back.sv]
// ----------------------------------------------------------------------------
// u2u8_back
// Sends each job's UTF-8 bytes and any terminator, one beat per ready cycle.
// ----------------------------------------------------------------------------
module u2u8_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  u2u8_pkg::job_type head_job,
   output logic              pop,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [7:0]        out_byte,
   output logic              out_term,
   output logic              out_last
);

   logic [u2u8_pkg::COUNT_W-1:0] idx_ff, idx_in;
   logic                         valid_ff, valid_in;
   logic [7:0]                   byte_ff;
   logic                         term_ff, last_ff;

   logic [u2u8_pkg::COUNT_W-1:0] total;
   logic                         load, last, at_term;
   logic [7:0]                   cur_byte;

   function automatic logic [7:0] cont(input logic [5:0] bits);
      cont = u2u8_pkg::CONT_MARK | ({2'b00, bits} & u2u8_pkg::CONT_MASK);
   endfunction

   function automatic logic [7:0] byte_at(input logic [u2u8_pkg::CP_W-1:0] cp,
                                          input logic [u2u8_pkg::LEN_W-1:0] len,
                                          input logic [u2u8_pkg::COUNT_W-1:0] k);
      logic [7:0] r;
      r = 8'd0;
      unique case (len)
         3'd1: r = cp[7:0];
         3'd2: r = (k == 3'd0) ? (u2u8_pkg::LEAD2 | {3'b000, cp[10:6]}) : cont(cp[5:0]);
         3'd3: begin
            unique case (k)
               3'd0:    r = u2u8_pkg::LEAD3 | {4'b0000, cp[15:12]};
               3'd1:    r = cont(cp[11:6]);
               default: r = cont(cp[5:0]);
            endcase
         end
         3'd4: begin
            unique case (k)
               3'd0:    r = u2u8_pkg::LEAD4 | {5'b00000, cp[20:18]};
               3'd1:    r = cont(cp[17:12]);
               3'd2:    r = cont(cp[11:6]);
               default: r = cont(cp[5:0]);
            endcase
         end
         default: r = 8'd0;
      endcase
      byte_at = r;
   endfunction

   always_comb begin
      total    = head_job.nbytes + {2'b00, head_job.term};
      load     = head_valid && (!valid_ff || out_ready);
      last     = (idx_ff == total - 1'b1);
      at_term  = (idx_ff == head_job.nbytes);
      cur_byte = at_term ? 8'd0 : byte_at(head_job.cp, head_job.nbytes, idx_ff);
      pop      = load && last;

      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         idx_in   = last ? '0 : idx_ff + 1'b1;
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= cur_byte;
         term_ff <= at_term;
         last_ff <= last;
      end
   end

   assign out_valid = valid_ff;
   assign out_byte  = byte_ff;
   assign out_term  = term_ff;
   assign out_last  = last_ff;

`ifndef SYNTHESIS
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> (idx_ff < total))
      else $error("beat index past job end");

   a_term_last: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && term_ff) |-> (last_ff && byte_ff == 8'd0))
      else $error("terminator not last beat of its item");
`endif

endmodule

[sv/utf16_to_utf8_transcoder_top.sv]
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder_top
// Streams source string bytes (UTF-16 either order, or Latin-1) into UTF-8.
// ----------------------------------------------------------------------------
//  channel  | dir | beat payload
//  ---------+-----+--------------------------------------------------------
//  req_bus  | in  | has_byte, source_byte[7:0], end_of_string
//  rsp_bus  | out | utf8_byte[7:0], is_terminator, run_last
//  csr_bus  | in  | index[1:0], wdata[CAPACITY_BITS-1:0] (always ready)
//
//  An input beat is taken in any cycle the job queue has room; the front
//  classifies it in that same cycle. The back sends one output beat per
//  cycle while rsp_bus is ready, and an item yields at most five beats.
//  Reset (synchronous, high) restores register defaults and string state.
//  A stalled rsp_bus fills the two-entry queue, then drops req_bus ready.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder_top #(
   parameter int CAPACITY_BITS = 16
) (
   input  logic           clock,
   input  logic           reset,
   u2u8_req_if.sink       req_bus,
   u2u8_rsp_if.source     rsp_bus,
   u2u8_csr_if.sink       csr_bus
);

   localparam logic [CAPACITY_BITS-1:0] CAP_RESET = CAPACITY_BITS'(256);

   // configuration registers
   logic                     latin_ff;
   logic                     default_be_ff;
   logic [CAPACITY_BITS-1:0] capacity_ff;

   // front to queue
   logic              push;
   u2u8_pkg::job_type push_job;
   logic              q_full;
   logic              in_fire;

   // queue to back
   logic              head_valid;
   u2u8_pkg::job_type head_job;
   logic              pop;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         latin_ff      <= 1'b0;
         default_be_ff <= 1'b0;
         capacity_ff   <= CAP_RESET;
      end else if (csr_bus.valid) begin
         // writes past the last register are dropped
         unique case (csr_bus.index)
            u2u8_pkg::CSR_SOURCE_FORMAT:      latin_ff      <= csr_bus.wdata[0];
            u2u8_pkg::CSR_DEFAULT_BIG_ENDIAN: default_be_ff <= csr_bus.wdata[0];
            u2u8_pkg::CSR_OUTPUT_CAPACITY:    capacity_ff   <= csr_bus.wdata;
            default: ;
         endcase
      end
   end

   // the front only needs queue room; items without output still wait for it
   assign req_bus.ready = !q_full;
   assign in_fire       = req_bus.valid && !q_full;

   u2u8_front #(
      .CAPACITY_BITS(CAPACITY_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .in_fire       (in_fire),
      .has_byte      (req_bus.has_byte),
      .source_byte   (req_bus.source_byte),
      .end_of_string (req_bus.end_of_string),
      .cfg_latin     (latin_ff),
      .cfg_default_be(default_be_ff),
      .cfg_capacity  (capacity_ff),
      .push          (push),
      .push_job      (push_job)
   );

   u2u8_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .full      (q_full),
      .head_valid(head_valid),
      .head_job  (head_job),
      .pop       (pop)
   );

   // back: one UTF-8 byte per beat from an output register
   u2u8_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_valid(head_valid),
      .head_job  (head_job),
      .pop       (pop),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_byte  (rsp_bus.utf8_byte),
      .out_term  (rsp_bus.is_terminator),
      .out_last  (rsp_bus.run_last)
   );

endmodule
